>>> design/tcd_pkg.sv
// shared types and constants of the trace record decoder
// parse phases, event and error codes, and the result struct
// no dependencies
package tcd_pkg;

    typedef enum logic [3:0] {
        PH_TAG,
        PH_ARR_HEAD,
        PH_ARR_EXT,
        PH_PATH_HEAD,
        PH_PATH_EXT,
        PH_PATH_BYTES,
        PH_FLAG,
        PH_HASH_HEAD,
        PH_HASH_EXT,
        PH_CONT_HEAD,
        PH_CONT_EXT,
        PH_CONT_BYTES,
        PH_STAT_HEAD,
        PH_STAT_EXT,
        PH_DONE,
        PH_HALT
    } phase_t;

    typedef enum logic [2:0] {
        EV_COUNT,
        EV_STR_START,
        EV_STR_NULL,
        EV_STR_BYTE,
        EV_FLAG,
        EV_HASH,
        EV_STATUS
    } ev_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_TAG,
        ERR_MALFORMED,
        ERR_EARLY_END,
        ERR_RANGE
    } err_t;

    typedef enum logic {
        OP_DATA,
        OP_END
    } op_t;

    localparam logic [7:0] TAG_BYTE   = 8'h54;
    localparam logic [7:0] NULL_BYTE  = 8'hF6;
    localparam logic [7:0] TRUE_BYTE  = 8'hF5;
    localparam logic [7:0] FALSE_BYTE = 8'hF4;

    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_TEXT  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;

    localparam logic [4:0] AI_IMM_MAX = 5'd23;
    localparam logic [4:0] AI_EXT_MAX = 5'd27;

    localparam logic [2:0] FLAG_COUNT = 3'd5;

    typedef struct packed {
        ev_t                kind;
        logic               which_string;
        logic [31:0]        entry_number;
        logic [2:0]         flag_number;
        logic [63:0]        field_value;
        logic signed [31:0] run_status;
        err_t               error_code;
        logic               record_done;
    } tcd_result_t;

endpackage

>>> design/tcd_parser.sv
// parse state and per-byte next-state logic of the trace record decoder
// holds the hash limit register; depends on tcd_pkg
module tcd_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [63:0]          cfg_wr_data,
    input  logic                 step,
    input  logic                 opcode,
    input  logic [7:0]           data_byte,
    output logic                 res_valid,
    output tcd_pkg::tcd_result_t res
);
    import tcd_pkg::*;

    logic [63:0] hash_limit_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  hbl_reg, hbl_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] entries_left_reg, entries_left_next;
    logic [31:0] entry_counter_reg, entry_counter_next;
    logic [63:0] sbl_reg, sbl_next;
    logic [2:0]  flag_counter_reg, flag_counter_next;

    logic        fin_req;
    phase_t      fin_kind;
    logic [63:0] fin_v;
    logic        so_req;
    logic        so_which;
    logic [2:0]  major;
    logic [4:0]  ai;
    logic [2:0]  want_major;
    logic        is_text_head;
    logic [63:0] acc_shift;
    logic [3:0]  hbl_dec;
    logic [63:0] sbl_dec;
    logic [2:0]  fc_inc;

    assign major     = data_byte[7:5];
    assign ai        = data_byte[4:0];
    assign acc_shift = {acc_reg[55:0], data_byte};
    assign hbl_dec   = (hbl_reg != 4'd0) ? hbl_reg - 4'd1 : 4'd0;
    assign sbl_dec   = (sbl_reg != 64'd0) ? sbl_reg - 64'd1 : 64'd0;
    assign fc_inc    = flag_counter_reg + 3'd1;
    assign is_text_head = (phase_reg == PH_PATH_HEAD) || (phase_reg == PH_CONT_HEAD);

    always_comb begin
        case (phase_reg)
            PH_ARR_HEAD:  want_major = MT_ARRAY;
            PH_PATH_HEAD: want_major = MT_TEXT;
            PH_CONT_HEAD: want_major = MT_TEXT;
            default:      want_major = MT_UINT;
        endcase
    end

    always_comb begin
        phase_next         = phase_reg;
        hbl_next           = hbl_reg;
        acc_next           = acc_reg;
        entries_left_next  = entries_left_reg;
        entry_counter_next = entry_counter_reg;
        sbl_next           = sbl_reg;
        flag_counter_next  = flag_counter_reg;
        res_valid          = 1'b0;
        res                = '0;
        fin_req            = 1'b0;
        fin_kind           = phase_reg;
        fin_v              = 64'd0;
        so_req             = 1'b0;
        so_which           = 1'b0;

        if (opcode == OP_END) begin
            if (phase_reg != PH_DONE && phase_reg != PH_HALT) begin
                res_valid       = 1'b1;
                res.error_code  = ERR_EARLY_END;
                res.record_done = 1'b1;
            end
            phase_next         = PH_TAG;
            hbl_next           = 4'd0;
            acc_next           = 64'd0;
            entries_left_next  = 32'd0;
            entry_counter_next = 32'd0;
            sbl_next           = 64'd0;
            flag_counter_next  = 3'd0;
        end else begin
            case (phase_reg)
                PH_TAG: begin
                    if (data_byte != TAG_BYTE) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_TAG;
                        res.record_done = 1'b1;
                    end else begin
                        phase_next = PH_ARR_HEAD;
                    end
                end
                PH_ARR_HEAD, PH_PATH_HEAD, PH_HASH_HEAD, PH_CONT_HEAD, PH_STAT_HEAD: begin
                    if (is_text_head && data_byte == NULL_BYTE) begin
                        res_valid        = 1'b1;
                        res.kind         = EV_STR_NULL;
                        res.which_string = (phase_reg == PH_CONT_HEAD);
                        res.entry_number = entry_counter_reg;
                        so_req           = 1'b1;
                        so_which         = (phase_reg == PH_CONT_HEAD);
                    end else if (major != want_major || ai > AI_EXT_MAX) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_MALFORMED;
                        res.record_done = 1'b1;
                    end else if (ai <= AI_IMM_MAX) begin
                        fin_req  = 1'b1;
                        fin_kind = phase_reg;
                        fin_v    = {59'd0, ai};
                    end else begin
                        case (ai[1:0])
                            2'd0:    hbl_next = 4'd1;
                            2'd1:    hbl_next = 4'd2;
                            2'd2:    hbl_next = 4'd4;
                            default: hbl_next = 4'd8;
                        endcase
                        acc_next = 64'd0;
                        case (phase_reg)
                            PH_ARR_HEAD:  phase_next = PH_ARR_EXT;
                            PH_PATH_HEAD: phase_next = PH_PATH_EXT;
                            PH_HASH_HEAD: phase_next = PH_HASH_EXT;
                            PH_CONT_HEAD: phase_next = PH_CONT_EXT;
                            default:      phase_next = PH_STAT_EXT;
                        endcase
                    end
                end
                PH_ARR_EXT, PH_PATH_EXT, PH_HASH_EXT, PH_CONT_EXT, PH_STAT_EXT: begin
                    acc_next = acc_shift;
                    hbl_next = hbl_dec;
                    if (hbl_dec == 4'd0) begin
                        fin_req = 1'b1;
                        fin_v   = acc_shift;
                        case (phase_reg)
                            PH_ARR_EXT:  fin_kind = PH_ARR_HEAD;
                            PH_PATH_EXT: fin_kind = PH_PATH_HEAD;
                            PH_HASH_EXT: fin_kind = PH_HASH_HEAD;
                            PH_CONT_EXT: fin_kind = PH_CONT_HEAD;
                            default:     fin_kind = PH_STAT_HEAD;
                        endcase
                    end
                end
                PH_PATH_BYTES, PH_CONT_BYTES: begin
                    res_valid        = 1'b1;
                    res.kind         = EV_STR_BYTE;
                    res.which_string = (phase_reg == PH_CONT_BYTES);
                    res.entry_number = entry_counter_reg;
                    res.field_value  = {56'd0, data_byte};
                    sbl_next         = sbl_dec;
                    if (sbl_dec == 64'd0) begin
                        so_req   = 1'b1;
                        so_which = (phase_reg == PH_CONT_BYTES);
                    end
                end
                PH_FLAG: begin
                    if (data_byte != TRUE_BYTE && data_byte != FALSE_BYTE) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_MALFORMED;
                        res.record_done = 1'b1;
                    end else begin
                        res_valid        = 1'b1;
                        res.kind         = EV_FLAG;
                        res.entry_number = entry_counter_reg;
                        res.flag_number  = flag_counter_reg;
                        res.field_value  = {63'd0, data_byte == TRUE_BYTE};
                        if (fc_inc >= FLAG_COUNT) begin
                            flag_counter_next = 3'd0;
                            phase_next        = PH_HASH_HEAD;
                        end else begin
                            flag_counter_next = fc_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (fin_req) begin
            case (fin_kind)
                PH_ARR_HEAD: begin
                    if (fin_v[63:32] != 32'd0) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_MALFORMED;
                        res.record_done = 1'b1;
                    end else begin
                        entries_left_next  = fin_v[31:0];
                        entry_counter_next = 32'd0;
                        phase_next = (fin_v == 64'd0) ? PH_STAT_HEAD : PH_PATH_HEAD;
                        res_valid       = 1'b1;
                        res.kind        = EV_COUNT;
                        res.field_value = fin_v;
                    end
                end
                PH_PATH_HEAD, PH_CONT_HEAD: begin
                    res_valid        = 1'b1;
                    res.kind         = EV_STR_START;
                    res.which_string = (fin_kind == PH_CONT_HEAD);
                    res.entry_number = entry_counter_reg;
                    res.field_value  = fin_v;
                    sbl_next         = fin_v;
                    if (fin_v == 64'd0) begin
                        so_req   = 1'b1;
                        so_which = (fin_kind == PH_CONT_HEAD);
                    end else begin
                        phase_next = (fin_kind == PH_CONT_HEAD) ? PH_CONT_BYTES
                                                                : PH_PATH_BYTES;
                    end
                end
                PH_HASH_HEAD: begin
                    if (fin_v > hash_limit_reg) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_MALFORMED;
                        res.record_done = 1'b1;
                    end else begin
                        phase_next       = PH_CONT_HEAD;
                        res_valid        = 1'b1;
                        res.kind         = EV_HASH;
                        res.entry_number = entry_counter_reg;
                        res.field_value  = fin_v;
                    end
                end
                default: begin
                    if (fin_v[63:31] != 33'd0 && fin_v[63:31] != {33{1'b1}}) begin
                        phase_next      = PH_HALT;
                        res_valid       = 1'b1;
                        res.error_code  = ERR_RANGE;
                        res.record_done = 1'b1;
                    end else begin
                        phase_next      = PH_DONE;
                        res_valid       = 1'b1;
                        res.kind        = EV_STATUS;
                        res.run_status  = fin_v[31:0];
                        res.record_done = 1'b1;
                    end
                end
            endcase
        end

        if (so_req) begin
            if (so_which) begin
                entry_counter_next = entry_counter_reg + 32'd1;
                entries_left_next  = entries_left_reg - 32'd1;
                phase_next = (entries_left_reg == 32'd1) ? PH_STAT_HEAD : PH_PATH_HEAD;
            end else begin
                flag_counter_next = 3'd0;
                phase_next        = PH_FLAG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_limit_reg    <= {64{1'b1}};
            phase_reg         <= PH_TAG;
            hbl_reg           <= 4'd0;
            acc_reg           <= 64'd0;
            entries_left_reg  <= 32'd0;
            entry_counter_reg <= 32'd0;
            sbl_reg           <= 64'd0;
            flag_counter_reg  <= 3'd0;
        end else begin
            if (cfg_wr_en) begin
                hash_limit_reg <= cfg_wr_data;
            end
            if (step) begin
                phase_reg         <= phase_next;
                hbl_reg           <= hbl_next;
                acc_reg           <= acc_next;
                entries_left_reg  <= entries_left_next;
                entry_counter_reg <= entry_counter_next;
                sbl_reg           <= sbl_next;
                flag_counter_reg  <= flag_counter_next;
            end
        end
    end

    a_flag_counter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        flag_counter_reg < FLAG_COUNT)
        else $error("flag counter out of range");

    a_ext_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ARR_EXT || phase_reg == PH_PATH_EXT || phase_reg == PH_HASH_EXT ||
         phase_reg == PH_CONT_EXT || phase_reg == PH_STAT_EXT) |-> hbl_reg != 4'd0)
        else $error("extension phase with no bytes left");

    a_bytes_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PATH_BYTES || phase_reg == PH_CONT_BYTES) |-> sbl_reg != 64'd0)
        else $error("string byte phase with empty length");

endmodule

>>> design/trace_record_cbor_decoder_top.sv
// top level of the trace record decoder: input register, parser, result register
// depends on tcd_pkg and tcd_parser
//
// usage
// - s_ channel: one beat per record byte; s_tuser[0] is 1 for end of buffer, which
//   also returns the parser to the start of a record; s_tdata carries the byte
// - m_ channel: at most one result beat per input beat; m_tuser is the event kind,
//   m_tlast marks the final beat of a record (exit status or error)
// - cfg_wr_en / cfg_wr_data write the hash limit; write only while the block is idle
// - a byte on s_ passes the input register, the parser, then the result register
// - throughput: one byte per cycle while m_tready is high; the per-byte state update
//   is one combinational pass between the input register and the result register
// - reset (aresetn low, synchronous) empties both registers, puts the parser at the
//   tag byte and sets the hash limit to all ones
// - when m_tready is low a pending result holds; the input register still takes one
//   more beat, then s_tready drops until the result is taken
module trace_record_cbor_decoder_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [63:0]    cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // data_byte
    input  logic [0:0]     s_tuser,   // opcode
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [135:0]   m_tdata,   // which_string, entry_number, flag_number,
                                      // field_value, run_status, error_code, pad
    output logic [2:0]     m_tuser,   // event_res
    output logic           m_tlast    // record_done
);
    import tcd_pkg::*;

    logic        in_valid_reg;
    logic        in_opcode_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    tcd_result_t out_res_reg;
    logic        advance;
    logic        s_accept;
    logic        res_valid;
    tcd_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    tcd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .opcode      (in_opcode_reg),
        .data_byte   (in_byte_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_opcode_reg <= s_tuser[0];
            in_byte_reg   <= s_tdata;
        end
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.record_done;
    assign m_tdata  = {1'b0, out_res_reg.error_code, out_res_reg.run_status,
                       out_res_reg.field_value, out_res_reg.flag_number,
                       out_res_reg.entry_number, out_res_reg.which_string};

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled input beat lost");

    a_done_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.record_done |->
            out_res_reg.kind == EV_STATUS || out_res_reg.error_code != ERR_NONE)
        else $error("record end on a non-final result");

    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.error_code != ERR_NONE |->
            out_res_reg.kind == EV_COUNT && out_res_reg.record_done &&
            out_res_reg.field_value == 64'd0 && out_res_reg.entry_number == 32'd0)
        else $error("error result carries field data");

endmodule

>>> tb/sv/tb_trace_record_cbor_decoder_top.sv
// self-checking testbench for trace_record_cbor_decoder_top: directed and random records
// are fed as byte beats while a per-byte predictor queues the expected result beats in order
// depends on tcd_pkg and the decoder rtl
module tb_trace_record_cbor_decoder_top;
    import tcd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BEATS = 1500;

    logic           aclk;
    logic           aresetn;
    logic           cfg_wr_en;
    logic [63:0]    cfg_wr_data;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;
    logic [0:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;
    logic [2:0]     m_tuser;
    logic           m_tlast;

    trace_record_cbor_decoder_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // predictor state
    phase_t      ph;
    int unsigned head_left;
    logic [63:0] acc;
    logic [31:0] ents_left;
    logic [31:0] ent_cnt;
    logic [63:0] str_left;
    logic [2:0]  flag_cnt;
    logic [63:0] hash_lim;

    tcd_result_t pending_events[$];
    logic [7:0]  frame_q[$];

    bit steady;
    int cycle_count;
    int mismatch_count;
    int checked_count;
    int live_beats;
    int frames_sent;
    int limit_writes;
    tcd_result_t seen_event;
    tcd_result_t want_event;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_trace_record_cbor_decoder_top: done, errors");
            $finish;
        end
    end

    function automatic void post_event(ev_t ev, logic which, logic [31:0] entry,
                                       logic [2:0] flag, logic [63:0] val,
                                       logic [31:0] status, err_t err, logic done);
        tcd_result_t r;
        r.kind         = ev;
        r.which_string = which;
        r.entry_number = entry;
        r.flag_number  = flag;
        r.field_value  = val;
        r.run_status   = status;
        r.error_code   = err;
        r.record_done  = done;
        pending_events.push_back(r);
    endfunction

    function automatic void clear_parse();
        ph        = PH_TAG;
        head_left = 0;
        acc       = '0;
        ents_left = '0;
        ent_cnt   = '0;
        str_left  = '0;
        flag_cnt  = '0;
    endfunction

    function automatic void halt_on(err_t err);
        ph = PH_HALT;
        post_event(EV_COUNT, 1'b0, '0, '0, '0, '0, err, 1'b1);
    endfunction

    function automatic void close_string(logic which);
        if (which) begin
            ent_cnt   = ent_cnt + 1;
            ents_left = ents_left - 1;
            ph = (ents_left == 0) ? PH_STAT_HEAD : PH_PATH_HEAD;
        end else begin
            flag_cnt = '0;
            ph = PH_FLAG;
        end
    endfunction

    // -1 bad head, 0 immediate, else number of extension bytes
    function automatic int head_size(logic [7:0] b, logic [7:0] base);
        int bi;
        int ba;
        bi = int'(b);
        ba = int'(base);
        if (bi >= ba && bi <= ba + 23)
            return 0;
        if (bi >= ba + 24 && bi <= ba + 27)
            return 1 << (bi - ba - 24);
        return -1;
    endfunction

    function automatic void finish_value(phase_t kind, logic [63:0] v);
        logic which;
        case (kind)
            PH_ARR_HEAD: begin
                if (v > 64'hFFFF_FFFF) begin
                    halt_on(ERR_MALFORMED);
                end else begin
                    ents_left = v[31:0];
                    ent_cnt = '0;
                    ph = (v == 0) ? PH_STAT_HEAD : PH_PATH_HEAD;
                    post_event(EV_COUNT, 1'b0, '0, '0, v, '0, ERR_NONE, 1'b0);
                end
            end
            PH_PATH_HEAD, PH_CONT_HEAD: begin
                which = (kind == PH_CONT_HEAD);
                post_event(EV_STR_START, which, ent_cnt, '0, v, '0, ERR_NONE, 1'b0);
                str_left = v;
                if (v == 0)
                    close_string(which);
                else
                    ph = which ? PH_CONT_BYTES : PH_PATH_BYTES;
            end
            PH_HASH_HEAD: begin
                if (v > hash_lim) begin
                    halt_on(ERR_MALFORMED);
                end else begin
                    ph = PH_CONT_HEAD;
                    post_event(EV_HASH, 1'b0, ent_cnt, '0, v, '0, ERR_NONE, 1'b0);
                end
            end
            default: begin
                if (!(v <= 64'h7FFF_FFFF || v >= 64'hFFFF_FFFF_8000_0000)) begin
                    halt_on(ERR_RANGE);
                end else begin
                    ph = PH_DONE;
                    post_event(EV_STATUS, 1'b0, '0, '0, '0, v[31:0], ERR_NONE, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void take_head(logic [7:0] b);
        phase_t kind;
        logic [7:0] base;
        int n;
        kind = ph;
        if (kind == PH_ARR_HEAD)
            base = {MT_ARRAY, 5'd0};
        else if (kind == PH_PATH_HEAD || kind == PH_CONT_HEAD)
            base = {MT_TEXT, 5'd0};
        else
            base = {MT_UINT, 5'd0};
        if (base == {MT_TEXT, 5'd0} && b == NULL_BYTE) begin
            post_event(EV_STR_NULL, kind == PH_CONT_HEAD, ent_cnt, '0, '0, '0, ERR_NONE, 1'b0);
            close_string(kind == PH_CONT_HEAD);
            return;
        end
        n = head_size(b, base);
        if (n < 0) begin
            halt_on(ERR_MALFORMED);
        end else if (n == 0) begin
            finish_value(kind, 64'(b - base));
        end else begin
            head_left = n;
            acc = '0;
            ph = phase_t'(kind + 1);
        end
    endfunction

    function automatic void decode_byte(op_t op, logic [7:0] b);
        logic which;
        logic [2:0] fn;
        logic bit_val;
        if (op == OP_END) begin
            if (ph != PH_DONE && ph != PH_HALT)
                post_event(EV_COUNT, 1'b0, '0, '0, '0, '0, ERR_EARLY_END, 1'b1);
            clear_parse();
            return;
        end
        case (ph)
            PH_TAG: begin
                if (b != TAG_BYTE)
                    halt_on(ERR_TAG);
                else
                    ph = PH_ARR_HEAD;
            end
            PH_ARR_HEAD, PH_PATH_HEAD, PH_HASH_HEAD, PH_CONT_HEAD, PH_STAT_HEAD: begin
                take_head(b);
            end
            PH_ARR_EXT, PH_PATH_EXT, PH_HASH_EXT, PH_CONT_EXT, PH_STAT_EXT: begin
                acc = {acc[55:0], b};
                if (head_left > 0)
                    head_left--;
                if (head_left == 0)
                    finish_value(phase_t'(ph - 1), acc);
            end
            PH_PATH_BYTES, PH_CONT_BYTES: begin
                which = (ph == PH_CONT_BYTES);
                post_event(EV_STR_BYTE, which, ent_cnt, '0, 64'(b), '0, ERR_NONE, 1'b0);
                if (str_left > 0)
                    str_left--;
                if (str_left == 0)
                    close_string(which);
            end
            PH_FLAG: begin
                fn = flag_cnt;
                if (b == TRUE_BYTE) begin
                    bit_val = 1'b1;
                end else if (b == FALSE_BYTE) begin
                    bit_val = 1'b0;
                end else begin
                    halt_on(ERR_MALFORMED);
                    return;
                end
                post_event(EV_FLAG, 1'b0, ent_cnt, fn, 64'(bit_val), '0, ERR_NONE, 1'b0);
                flag_cnt = fn + 3'd1;
                if (flag_cnt >= FLAG_COUNT) begin
                    flag_cnt = '0;
                    ph = PH_HASH_HEAD;
                end
            end
            default: ;
        endcase
    endfunction

    // result side: random backpressure (none while steady) and comparison against the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_event.kind         = ev_t'(m_tuser);
                seen_event.which_string = m_tdata[0];
                seen_event.entry_number = m_tdata[32:1];
                seen_event.flag_number  = m_tdata[35:33];
                seen_event.field_value  = m_tdata[99:36];
                seen_event.run_status   = m_tdata[131:100];
                seen_event.error_code   = err_t'(m_tdata[134:132]);
                seen_event.record_done  = m_tlast;
                checked_count++;
                if (pending_events.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: ev=%0d err=%0d val=%h",
                                 seen_event.kind, seen_event.error_code,
                                 seen_event.field_value);
                end else begin
                    want_event = pending_events.pop_front();
                    if (seen_event.kind !== want_event.kind ||
                        seen_event.which_string !== want_event.which_string ||
                        seen_event.entry_number !== want_event.entry_number ||
                        seen_event.flag_number !== want_event.flag_number ||
                        seen_event.field_value !== want_event.field_value ||
                        seen_event.run_status !== want_event.run_status ||
                        seen_event.error_code !== want_event.error_code ||
                        seen_event.record_done !== want_event.record_done) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch exp: ev=%0d ws=%0d ent=%0d flag=%0d val=%h st=%0d err=%0d last=%0d",
                                     want_event.kind, want_event.which_string,
                                     want_event.entry_number, want_event.flag_number,
                                     want_event.field_value, want_event.run_status,
                                     want_event.error_code, want_event.record_done);
                            $display("         got: ev=%0d ws=%0d ent=%0d flag=%0d val=%h st=%0d err=%0d last=%0d",
                                     seen_event.kind, seen_event.which_string,
                                     seen_event.entry_number, seen_event.flag_number,
                                     seen_event.field_value, seen_event.run_status,
                                     seen_event.error_code, seen_event.record_done);
                        end
                    end
                end
            end
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
        end
    end

    task automatic send_byte(op_t op, logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 14) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        live_beats++;
        decode_byte(op, b);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(OP_DATA, frame_q[i]);
        send_byte(OP_END, 8'($urandom_range(0, 255)));
        frames_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_hash_limit(logic [63:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        hash_lim = v;
        limit_writes++;
    endtask

    // head with a random legal encoding: immediate or 1, 2, 4, 8 extension bytes
    function automatic void put_head(logic [2:0] major, logic [63:0] v);
        int k;
        int n;
        do begin
            k = $urandom_range(0, 4);
            n = (k == 0) ? 0 : (1 << (k - 1));
        end while (!((n == 0) ? (v <= 23) : (n == 8 || v < (64'd1 << (8 * n)))));
        if (n == 0) begin
            frame_q.push_back({major, v[4:0]});
        end else begin
            frame_q.push_back({major, 5'(AI_IMM_MAX + k)});
            for (int i = n - 1; i >= 0; i--)
                frame_q.push_back(v[8 * i +: 8]);
        end
    endfunction

    function automatic void put_text(int len);
        if (len < 0) begin
            frame_q.push_back(NULL_BYTE);
        end else begin
            put_head(MT_TEXT, 64'(len));
            repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic logic [63:0] pick_hash();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return hash_lim >> $urandom_range(0, 63);
            5, 6:          return 64'($urandom_range(0, 30));
            7:             return hash_lim;
            8:             return hash_lim + 1;
            default:       return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_status();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 64'($urandom_range(0, 100));
            4:          return 64'($urandom & 32'h7FFF_FFFF);
            5:          return 64'hFFFF_FFFF_8000_0000 | 64'($urandom & 32'h7FFF_FFFF);
            6:          return $urandom_range(0, 1) ? 64'h7FFF_FFFF : 64'hFFFF_FFFF_8000_0000;
            7:          return $urandom_range(0, 1) ? 64'h8000_0000 : 64'hFFFF_FFFF_7FFF_FFFF;
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_record();
        int n;
        int cut;
        int pick;
        frame_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            // noise buffer, possibly empty
            repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            frame_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : TAG_BYTE);
            n = $urandom_range(0, 3);
            put_head(MT_ARRAY, 64'(n));
            repeat (n) begin
                put_text(($urandom_range(0, 9) < 2) ? -1 : $urandom_range(0, 5));
                repeat (FLAG_COUNT) frame_q.push_back($urandom_range(0, 1) ? TRUE_BYTE : FALSE_BYTE);
                put_head(MT_UINT, pick_hash());
                put_text(($urandom_range(0, 9) < 2) ? -1 : $urandom_range(0, 5));
            end
            put_head(MT_UINT, pick_status());
            cut = $urandom_range(0, frame_q.size() - 1);
            if (pick < 16) begin
                frame_q[cut] = 8'($urandom_range(0, 255));
            end else if (pick < 24) begin
                while (frame_q.size() > cut) void'(frame_q.pop_back());
            end else if (pick < 32) begin
                repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 19) == 0)
            drain_results();
        send_frame();
    endtask

    task automatic test_valid_records();
        frame_q = {};
        send_frame();
        frame_q = {8'h54, 8'h80, 8'h00};
        send_frame();
        // null path, mixed flags, largest hash, two byte content, status -1, trailing bytes
        frame_q = {8'h54, 8'h81, 8'hF6, 8'hF5, 8'hF4, 8'hF5, 8'hF4, 8'hF5,
                   8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h62, 8'h00, 8'hFF,
                   8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h54, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h9A, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        frame_q = {8'h54, 8'h80, 8'h1A, 8'h7F, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        frame_q = {8'h54, 8'h80, 8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h80, 8'h00, 8'h00, 8'h00};
        send_frame();
    endtask

    task automatic test_error_records();
        frame_q = {8'h55, 8'h80, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h9B, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h9C};
        send_frame();
        frame_q = {8'h54, 8'h81, 8'h7C};
        send_frame();
        frame_q = {8'h54, 8'h81, 8'h60, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h80, 8'h1A, 8'h80, 8'h00, 8'h00, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h80, 8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                   8'h7F, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        frame_q = {8'h54, 8'h81, 8'h63, 8'h41};
        send_frame();
    endtask

    task automatic test_hash_limit();
        set_hash_limit(64'd0);
        frame_q = {8'h54, 8'h81, 8'hF6, 8'hF4, 8'hF4, 8'hF4, 8'hF4, 8'hF4,
                   8'h00, 8'hF6, 8'h00};
        send_frame();
        frame_q = {8'h54, 8'h81, 8'hF6, 8'hF4, 8'hF4, 8'hF4, 8'hF4, 8'hF4, 8'h01};
        send_frame();
        set_hash_limit(64'd1000);
        frame_q = {8'h54, 8'h81, 8'h60, 8'hF5, 8'hF5, 8'hF5, 8'hF5, 8'hF5,
                   8'h19, 8'h03, 8'hE8, 8'h60, 8'h17};
        send_frame();
        frame_q = {8'h54, 8'h81, 8'h60, 8'hF5, 8'hF5, 8'hF5, 8'hF5, 8'hF5,
                   8'h19, 8'h03, 8'hE9};
        send_frame();
    endtask

    task automatic test_random_records();
        logic [63:0] limits[5];
        int start;
        limits[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        limits[1] = {$urandom, $urandom};
        limits[2] = 64'd0;
        limits[3] = 64'($urandom_range(0, 65535));
        limits[4] = {$urandom, $urandom} >> $urandom_range(0, 63);
        foreach (limits[p]) begin
            set_hash_limit(limits[p]);
            steady = (p == 3);
            start = live_beats;
            while (live_beats - start < RANDOM_BEATS / 5)
                random_record();
        end
        steady = 1'b0;
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= OP_DATA;
        hash_lim = 64'hFFFF_FFFF_FFFF_FFFF;
        clear_parse();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_valid_records();
        test_error_records();
        test_hash_limit();
        test_random_records();

        drain_results();
        repeat (8) @(posedge aclk);
        $display("sent %0d buffers (%0d beats) under %0d hash limit settings",
                 frames_sent, live_beats, limit_writes);
        $display("checked %0d result beats, %0d mismatches, %0d still expected",
                 checked_count, mismatch_count, pending_events.size());
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("tb_trace_record_cbor_decoder_top: done, clean");
        else
            $display("tb_trace_record_cbor_decoder_top: done, errors");
        $finish;
    end

endmodule
